### src/cke_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cke_pkg
// shared types, constants and helpers of the key erasure generator
// ----------------------------------------------------------------------------
package cke_pkg;

  localparam int unsigned MAX_WORDS_DEFAULT = 64;
  localparam logic [31:0] RESEED_DEFAULT    = 32'h0010_0000;

  localparam logic OP_ABSORB   = 1'b0;
  localparam logic OP_GENERATE = 1'b1;

  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  typedef logic [7:0][31:0]  key_t;
  typedef logic [15:0][31:0] blk_t;

  // one quarter round step: two steps update a/d, two update c/b
  typedef logic [1:0] qr_step_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {v, v} << n;
    return dbl[63:32];
  endfunction

  function automatic blk_t block_init(input key_t key, input logic [63:0] ctr,
                                      input logic [63:0] nonce);
    blk_t w;
    w[0] = SIGMA0;
    w[1] = SIGMA1;
    w[2] = SIGMA2;
    w[3] = SIGMA3;
    for (int i = 0; i < 8; i++) begin
      w[4 + i] = key[i];
    end
    w[12] = ctr[31:0];
    w[13] = ctr[63:32];
    w[14] = nonce[31:0];
    w[15] = nonce[63:32];
    return w;
  endfunction

endpackage

`default_nettype wire

### src/cke_qr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cke_qr
// shared add / xor / rotate unit, one quarter round step per cycle
// ----------------------------------------------------------------------------
module cke_qr (
  input  wire cke_pkg::qr_step_t step,
  input  wire logic [31:0]       a,
  input  wire logic [31:0]       b,
  input  wire logic [31:0]       c,
  input  wire logic [31:0]       d,
  output logic [31:0]            a_out,
  output logic [31:0]            b_out,
  output logic [31:0]            c_out,
  output logic [31:0]            d_out
);
  import cke_pkg::*;

  logic [31:0] p;
  logic [31:0] q;
  logic [31:0] r;
  logic [31:0] sum;
  logic [31:0] rot;
  logic [4:0]  amt;

  always_comb begin
    case (step)
      2'd0:    amt = 5'd16;
      2'd1:    amt = 5'd12;
      2'd2:    amt = 5'd8;
      default: amt = 5'd7;
    endcase
  end

  // odd steps work on c += d, b ^= c; even steps on a += b, d ^= a
  assign p   = step[0] ? c : a;
  assign q   = step[0] ? d : b;
  assign r   = step[0] ? b : d;
  assign sum = p + q;
  assign rot = rotl(r ^ sum, amt);

  assign a_out = step[0] ? a : sum;
  assign d_out = step[0] ? d : rot;
  assign c_out = step[0] ? sum : c;
  assign b_out = step[0] ? rot : b;

endmodule

`default_nettype wire

### src/chacha20_key_erasure_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chacha20_key_erasure_generator
// chacha20 random generator with fast key erasure, one shared quarter-round unit
// ----------------------------------------------------------------------------
// one block: a load step, ten double rounds (column steps, diagonalise, diagonal
//   steps, undiagonalise), a final feed-forward step, all on the single step unit
// absorb item: taken at once, or followed by a key mixing block when it ends the run
// generate item of n words: the key rotation block gives up to 8 words, one more
//   block follows for each further 16 words, and each word waits on the output handshake
// rst (synchronous) clears key, nonce, counters and sets the default limit
// ----------------------------------------------------------------------------
module chacha20_key_erasure_generator #(
  parameter int unsigned MAX_WORDS = cke_pkg::MAX_WORDS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: reseed_limit
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // data_word [31:0], word_count [38:32], zero pad
  input  wire logic        s_tuser,   // op
  input  wire logic        s_tlast,   // last_word
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // random_word [31:0]
  output logic             m_tuser,   // reseed_due
  output logic             m_tlast    // last_of_run
);
  import cke_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOAD   = 6'b000010,
    S_ROUND  = 6'b000100,
    S_DIAG   = 6'b001000,
    S_UNDIAG = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  localparam logic [6:0] MAX_W = 7'(MAX_WORDS);

  state_t      state;
  logic [31:0] reseed_limit;
  key_t        key;
  logic [63:0] nonce;
  logic [2:0]  absorb_pos;
  logic [31:0] bytes_since;
  logic [63:0] blk_ctr;
  blk_t        x;
  logic        final_step;  // feed-forward pending after last round
  logic        gen_mode;    // block belongs to a generate request
  logic        first_blk;   // key rotation block
  logic        due;
  logic [6:0]  remaining;
  logic [3:0]  idx;
  logic [3:0]  dround;
  logic [1:0]  qr_cnt;
  qr_step_t    step;
  logic        diag;

  logic        in_acc;
  logic [31:0] in_data;
  logic [6:0]  in_count;
  logic [6:0]  count_cl;
  logic [32:0] byte_sum;
  blk_t        init_w;
  logic [31:0] qa, qb, qc, qd;
  logic        emit_go;

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign in_data  = s_tdata[31:0];
  assign in_count = s_tdata[38:32];
  assign count_cl = (in_count > MAX_W) ? MAX_W : in_count;
  assign byte_sum = {1'b0, bytes_since} + {24'd0, count_cl, 2'b00};
  assign init_w   = block_init(key, blk_ctr, nonce);
  assign emit_go  = (state == S_EMIT) && (!m_tvalid || m_tready);

  // shared step unit always sits on column 0; rows rotate past it
  cke_qr u_qr (
    .step  (step),
    .a     (x[0]),
    .b     (x[4]),
    .c     (x[8]),
    .d     (x[12]),
    .a_out (qa),
    .b_out (qb),
    .c_out (qc),
    .d_out (qd)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      reseed_limit <= RESEED_DEFAULT;
    end else if (cfg_we) begin
      reseed_limit <= cfg_wdata;
    end
  end

  // result valid: set on a new word, dropped once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      key         <= '0;
      nonce       <= '0;
      absorb_pos  <= '0;
      bytes_since <= '0;
      blk_ctr     <= '0;
      final_step  <= 1'b0;
      gen_mode    <= 1'b0;
      first_blk   <= 1'b0;
      due         <= 1'b0;
      remaining   <= '0;
      idx         <= '0;
      dround      <= '0;
      qr_cnt      <= '0;
      step        <= '0;
      diag        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (s_tuser == OP_ABSORB) begin
              if (s_tlast) begin
                // fold the word in, then mix the key with one block
                key[absorb_pos] <= key[absorb_pos] ^ in_data;
                absorb_pos      <= '0;
                bytes_since     <= '0;
                nonce           <= nonce + 64'd1;
                blk_ctr         <= '0;
                gen_mode        <= 1'b0;
                first_blk       <= 1'b1;
                state           <= S_LOAD;
              end else begin
                key[absorb_pos] <= key[absorb_pos] ^ in_data;
                absorb_pos      <= absorb_pos + 3'd1;
              end
            end else begin
              due         <= (bytes_since > reseed_limit);
              bytes_since <= byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];
              remaining   <= count_cl;
              nonce       <= nonce + 64'd1;
              blk_ctr     <= '0;
              gen_mode    <= 1'b1;
              first_blk   <= 1'b1;
              state       <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          x          <= init_w;
          dround     <= '0;
          qr_cnt     <= '0;
          step       <= '0;
          diag       <= 1'b0;
          final_step <= 1'b0;
          state      <= S_ROUND;
        end
        S_ROUND: begin
          if (final_step) begin
            // feed-forward add, key erasure on the rotation block
            for (int i = 0; i < 16; i++) begin
              x[i] <= x[i] + init_w[i];
            end
            final_step <= 1'b0;
            if (first_blk) begin
              for (int i = 0; i < 8; i++) begin
                key[i] <= x[i] + init_w[i];
              end
              idx <= 4'd8;
            end else begin
              blk_ctr <= blk_ctr + 64'd1;
              idx     <= 4'd0;
            end
            first_blk <= 1'b0;
            if (!gen_mode || remaining == '0) begin
              state <= S_IDLE;
            end else begin
              state <= S_EMIT;
            end
          end else begin
            step <= step + 2'd1;
            if (step == 2'd3) begin
              // write back, then bring the next column under the unit
              for (int r = 0; r < 4; r++) begin
                for (int i = 0; i < 4; i++) begin
                  if (i == 3) begin
                    x[4 * r + i] <= (r == 0) ? qa : (r == 1) ? qb : (r == 2) ? qc : qd;
                  end else begin
                    x[4 * r + i] <= x[4 * r + ((i + 1) % 4)];
                  end
                end
              end
              qr_cnt <= qr_cnt + 2'd1;
              if (qr_cnt == 2'd3) begin
                state <= diag ? S_UNDIAG : S_DIAG;
              end
            end else begin
              x[0]  <= qa;
              x[4]  <= qb;
              x[8]  <= qc;
              x[12] <= qd;
            end
          end
        end
        S_DIAG: begin
          for (int r = 0; r < 4; r++) begin
            for (int i = 0; i < 4; i++) begin
              x[4 * r + i] <= x[4 * r + ((i + r) % 4)];
            end
          end
          diag  <= 1'b1;
          state <= S_ROUND;
        end
        S_UNDIAG: begin
          for (int r = 0; r < 4; r++) begin
            for (int i = 0; i < 4; i++) begin
              x[4 * r + ((i + r) % 4)] <= x[4 * r + i];
            end
          end
          diag   <= 1'b0;
          dround <= dround + 4'd1;
          if (dround == 4'd9) begin
            final_step <= 1'b1;
          end
          state <= S_ROUND;
        end
        S_EMIT: begin
          if (emit_go) begin
            m_tdata   <= x[idx];
            m_tlast   <= (remaining == 7'd1);
            m_tuser   <= due;
            remaining <= remaining - 7'd1;
            idx       <= idx + 4'd1;
            if (remaining == 7'd1) begin
              state <= S_IDLE;
            end else if (idx == 4'd15) begin
              state <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a plain absorb word finishes at once and leaves the block ready
  a_absorb_ready: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_tuser == OP_ABSORB && !s_tlast) |=> s_tready)
    else $error("absorb word did not return to ready");

  // a word is only emitted while words of the request remain
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (remaining != '0))
    else $error("emit with no words left");

  // the final word of a run always hands control back to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_go && remaining == 7'd1) |=> (s_tready && m_tvalid && m_tlast))
    else $error("last word did not end the run");

  // the double round count never passes ten
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (dround <= 4'd10))
    else $error("double round count overrun");

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the chacha20 key erasure generator: drives absorb
// and generate items, predicts every random word with its own chacha20 model
// ----------------------------------------------------------------------------
module tb_top;
  import cke_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // data_word [31:0], word_count [38:32], zero pad
  logic        s_tuser;   // op
  logic        s_tlast;   // last_word
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // random_word [31:0]
  logic        m_tuser;   // reseed_due
  logic        m_tlast;   // last_of_run

  chacha20_key_erasure_generator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        due;
  } rand_word_t;

  // predictor state
  logic [31:0] gen_limit;
  logic [31:0] gen_key [8];
  logic [63:0] gen_nonce;
  logic [2:0]  gen_pos;
  logic [31:0] gen_bytes;
  logic [63:0] gen_ctr;
  rand_word_t  words_due [$];

  int send_idle_pct;
  int recv_idle_pct;
  bit recv_hold;
  bit failed;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // chacha20 block of the current key, counter and nonce
  function automatic void keystream_block(output logic [31:0] res [16]);
    logic [31:0] x [16];
    logic [31:0] init [16];
    int qa [8], qb [8], qc [8], qd [8];
    qa = '{0, 1, 2, 3, 0, 1, 2, 3};
    qb = '{4, 5, 6, 7, 5, 6, 7, 4};
    qc = '{8, 9, 10, 11, 10, 11, 8, 9};
    qd = '{12, 13, 14, 15, 15, 12, 13, 14};
    init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
    for (int i = 0; i < 8; i++) init[4 + i] = gen_key[i];
    init[12] = gen_ctr[31:0];
    init[13] = gen_ctr[63:32];
    init[14] = gen_nonce[31:0];
    init[15] = gen_nonce[63:32];
    x = init;
    for (int r = 0; r < 10; r++) begin
      for (int q = 0; q < 8; q++) begin
        x[qa[q]] += x[qb[q]]; x[qd[q]] ^= x[qa[q]];
        x[qd[q]] = {x[qd[q]][15:0], x[qd[q]][31:16]};
        x[qc[q]] += x[qd[q]]; x[qb[q]] ^= x[qc[q]];
        x[qb[q]] = {x[qb[q]][19:0], x[qb[q]][31:20]};
        x[qa[q]] += x[qb[q]]; x[qd[q]] ^= x[qa[q]];
        x[qd[q]] = {x[qd[q]][23:0], x[qd[q]][31:24]};
        x[qc[q]] += x[qd[q]]; x[qb[q]] ^= x[qc[q]];
        x[qb[q]] = {x[qb[q]][24:0], x[qb[q]][31:25]};
      end
    end
    for (int i = 0; i < 16; i++) res[i] = x[i] + init[i];
  endfunction

  // nonce step and key erasure
  function automatic void erase_key(output logic [31:0] res [16]);
    gen_nonce++;
    gen_ctr = '0;
    keystream_block(res);
    for (int i = 0; i < 8; i++) gen_key[i] = res[i];
  endfunction

  function automatic void predict_item(logic op, logic [31:0] data, logic last,
                                       logic [6:0] count_in);
    logic [31:0] blk [16];
    int          count;
    int          idx;
    logic        due;
    logic [32:0] sum;
    if (op == OP_ABSORB) begin
      gen_key[gen_pos] ^= data;
      gen_pos++;
      if (last) begin
        erase_key(blk);
        gen_bytes = '0;
        gen_pos = '0;
      end
      return;
    end
    count = (count_in > 64) ? 64 : count_in;
    due = gen_bytes > gen_limit;
    sum = {1'b0, gen_bytes} + 33'(4 * count);
    gen_bytes = sum[32] ? 32'hffff_ffff : sum[31:0];
    erase_key(blk);
    idx = 8;
    for (int k = 0; k < count; k++) begin
      if (idx >= 16) begin
        keystream_block(blk);
        gen_ctr++;
        idx = 0;
      end
      words_due.push_back('{blk[idx], k + 1 == count, due});
      idx++;
    end
  endfunction

  // valid stays up after the accepting edge; a drain, or an idle wait in the next call, drops it
  task automatic send_item(logic op, logic [31:0] data, logic last, logic [6:0] count);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tlast  <= last;
    s_tdata  <= {1'b0, count, data};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(op, data, last, count);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    // a final absorb word can still be mixing the key
    repeat (400) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    gen_limit = value;
  endtask

  task automatic send_random_item();
    int kind;
    kind = $urandom_range(99);
    if (kind < 45)
      send_item(OP_ABSORB, $urandom, $urandom_range(7) == 0, 7'($urandom));
    else if (kind < 90)
      send_item(OP_GENERATE, $urandom, 1'($urandom_range(1)),
                7'($urandom_range(1, 24)));
    else
      send_item(OP_GENERATE, $urandom, 1'($urandom_range(1)),
                7'($urandom_range(0, 127)));
  endtask

  // result checker
  always @(posedge clk) begin
    rand_word_t exp_w;
    if (!rst && m_tvalid && m_tready) begin
      if (words_due.size() == 0) begin
        $display("%0t unexpected item: word %h last %b due %b",
                 $time, m_tdata, m_tlast, m_tuser);
        failed = 1'b1;
      end else begin
        exp_w = words_due.pop_front();
        if (m_tdata !== exp_w.word) begin
          $display("%0t random_word expected %h actual %h", $time, exp_w.word, m_tdata);
          failed = 1'b1;
        end
        if (m_tlast !== exp_w.last) begin
          $display("%0t last_of_run expected %b actual %b", $time, exp_w.last, m_tlast);
          failed = 1'b1;
        end
        if (m_tuser !== exp_w.due) begin
          $display("%0t reseed_due expected %b actual %b", $time, exp_w.due, m_tuser);
          failed = 1'b1;
        end
      end
    end
  end

  // receiver ready, with random stalls and a long hold-off on request
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !recv_hold && !($urandom_range(99) < recv_idle_pct);
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 40000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(OP_GENERATE, 32'h0, 1'b0, 7'd1);          // zero key, smallest run
    send_item(OP_GENERATE, 32'hffff_ffff, 1'b1, 7'd8);  // only the rotation block
    send_item(OP_GENERATE, 32'h0, 1'b0, 7'd9);          // first extra block
    send_item(OP_GENERATE, 32'h0, 1'b0, 7'd64);         // largest run
    send_item(OP_GENERATE, 32'h0, 1'b0, 7'd127);        // clamped to the maximum
    send_item(OP_GENERATE, 32'h0, 1'b0, 7'd0);          // rotation without output
    send_item(OP_GENERATE, 32'h0, 1'b0, 7'd65);
    for (int i = 0; i < 9; i++)                         // position wraps past 8
      send_item(OP_ABSORB, (i % 2) ? 32'hffff_ffff : 32'h0, 1'b0, 7'd127);
    send_item(OP_ABSORB, 32'ha5a5_5a5a, 1'b1, 7'd0);    // key mixing
    send_item(OP_GENERATE, 32'h0, 1'b0, 7'd24);
    send_item(OP_ABSORB, 32'h1234_5678, 1'b1, 7'd64);   // mixing from position 0
    send_item(OP_GENERATE, 32'h0, 1'b0, 7'd3);
  endtask

  task automatic test_limits();
    write_limit(32'h0);          // due after any output
    send_item(OP_GENERATE, 32'h0, 1'b0, 7'd1);
    send_item(OP_GENERATE, 32'h0, 1'b0, 7'd2);
    send_item(OP_ABSORB, 32'h0, 1'b1, 7'd0);  // count cleared
    send_item(OP_GENERATE, 32'h0, 1'b0, 7'd1);
    write_limit(32'hffff_ffff);  // never due
    send_item(OP_GENERATE, 32'h0, 1'b0, 7'd4);
    write_limit(32'd40);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_random_item();
  endtask

  task automatic test_pressure();
    // receiver holds off while items keep coming
    recv_hold = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 4; i++) send_item(OP_GENERATE, $urandom, 1'b0, 7'd20);
    join
    // sender pauses until all results are in
    wait_drained();
    send_item(OP_GENERATE, 32'h0, 1'b0, 7'd5);
  endtask

  initial begin
    rst = 1'b1; cfg_we = 1'b0; cfg_wdata = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0; s_tlast = 1'b0;
    recv_hold = 1'b0; failed = 1'b0; quiet_cycles = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    gen_limit = RESEED_DEFAULT;
    for (int i = 0; i < 8; i++) gen_key[i] = '0;
    gen_nonce = '0; gen_pos = '0; gen_bytes = '0; gen_ctr = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_limits();
    send_idle_pct = 7; recv_idle_pct = 53;
    test_random(70);
    write_limit(32'd200);
    send_idle_pct = 53; recv_idle_pct = 7;
    test_random(70);
    write_limit(RESEED_DEFAULT);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(60);
    test_pressure();

    wait_drained();
    if (!failed) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
